// ===== src/ucd_pkg.sv =====
// Shared types, constants and the Fibonacci weight function for the integer code decoder.
package ucd_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int FIB_TERMS_DEF  = 46;
    localparam int OUT_W          = 32;
    localparam int LEN_W          = 33;
    localparam int IN_TDATA_W     = 8;

    typedef enum logic [1:0] {
        CK_GAMMA = 2'd0,
        CK_DELTA = 2'd1,
        CK_OMEGA = 2'd2,
        CK_FIB   = 2'd3
    } code_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_GZERO = 3'd1,
        PH_GBODY = 3'd2,
        PH_DZERO = 3'd3,
        PH_DLEN  = 3'd4,
        PH_DBODY = 3'd5,
        PH_OMEGA = 3'd6,
        PH_FIB   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             overflow;
    } ucd_result_t;

    typedef struct packed {
        logic emit;
        logic idle;
    } ucd_core_stat_t;

    // Zeckendorf weight 1,2,3,5,8,... at position idx, clipped to 2^vbits
    function automatic logic [63:0] fib_weight_cap(input int idx, input int vbits);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        logic [63:0] cap;
        a   = 64'd1;
        b   = 64'd2;
        cap = 64'd1 << vbits;
        for (int i = 0; i < idx; i++)
        begin
            t = a + b;
            a = b;
            b = t;
        end
        return (a >= cap) ? cap : a;
    endfunction

endpackage

// ===== src/universal_integer_code_decoder.sv =====
// Top level of the bit-serial Elias gamma/delta/omega and Fibonacci integer decoder.
//
//  Channel   Direction  Signals                     Contents
//  s_axis    in         tvalid tready tdata[7:0]    bit 0: bit_in, bits 7..1 zero
//  m_axis    out        tvalid tready tdata[31:0]   value
//                       tuser[0]                    overflow
//  cfg       in         cfg_wr_en cfg_wr_data[1:0]  code_kind
//
//  One stream bit per clock cycle while no bit that ends a codeword waits for the output
//  register; a result is presented at m_axis once the bit that ends its codeword has sat in
//  the input register and the decode core update has written the result straight into the output register.
//  The rate is set by the decode core, which updates its state once for each taken bit.
//  Reset puts the decoder at the start of a codeword with omega coding selected.
//  While a result waits at m_axis, bits that end no codeword keep flowing; a bit that
//  ends one waits in the input register until the output register is free.
module universal_integer_code_decoder
    import ucd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FIB_TERMS  = FIB_TERMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [0] bit_in, [7:1] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [31:0] value
    output logic                  m_axis_tuser,   // [0] overflow
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data
);

    localparam logic [VALUE_BITS-1:0] VMASK = '1;

    logic           in_held_valid;
    logic           in_held_bit;
    logic           consume;
    logic           out_load;
    logic           out_free;
    ucd_core_stat_t core_stat;
    ucd_result_t    core_res;
    ucd_result_t    out_res;

    // Input register
    ucd_input_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_bit     (s_axis_tdata[0]),
        .take       (consume),
        .held_valid (in_held_valid),
        .held_bit   (in_held_bit)
    );

    // Take a held bit unless its result has nowhere to go
    assign consume  = in_held_valid && (!core_stat.emit || out_free);
    assign out_load = consume && core_stat.emit;

    // Decode core
    ucd_decode_core #(
        .VALUE_BITS (VALUE_BITS),
        .FIB_TERMS  (FIB_TERMS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (consume),
        .bit_val     (in_held_bit),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (core_stat),
        .result      (core_res)
    );

    // Output register
    ucd_output_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .res_in    (core_res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .free      (out_free)
    );

    assign m_axis_tdata = out_res.value;
    assign m_axis_tuser = out_res.overflow;

    // A finished codeword leaves the core back at the start of a codeword
    a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> core_stat.idle)
        else $error("decoder not at codeword start after a result");

    // An overflowed result carries the saturated value
    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && core_res.overflow) |-> (core_res.value == OUT_W'(VMASK)))
        else $error("overflow result is not saturated");

    // Without overflow a decoded value fitting the port is never zero
    a_value_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !core_res.overflow && (VALUE_BITS <= OUT_W))
            |-> (core_res.value != '0))
        else $error("zero value decoded");

    // A result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !out_load)
        else $error("output register overwritten while stalled");

endmodule

// ===== src/ucd_input_reg.sv =====
// Input register stage: holds one stream bit until the decode core takes it.
module ucd_input_reg
    import ucd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_bit,
    input  logic take,
    output logic held_valid,
    output logic held_bit
);

    logic valid_reg;
    logic valid_next;
    logic bit_reg;

    // Free when empty or when the held bit leaves this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the bit of each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            bit_reg <= in_bit;
    end

    assign held_valid = valid_reg;
    assign held_bit   = bit_reg;

endmodule

// ===== src/ucd_decode_core.sv =====
// Decode core: codeword state and the per-bit update for gamma, delta, omega and Fibonacci.
module ucd_decode_core
    import ucd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FIB_TERMS  = FIB_TERMS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           bit_val,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_wr_data,
    output ucd_core_stat_t stat,
    output ucd_result_t    result
);

    localparam int VW = VALUE_BITS;
    localparam int AW = (VW > LEN_W) ? VW : LEN_W;
    localparam int FW = $clog2(FIB_TERMS + 1);
    localparam int IW = $clog2(FIB_TERMS);
    localparam logic [VW-1:0]    VMASK    = '1;
    localparam logic [LEN_W-1:0] LEN_CAP  = '1;
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [FW-1:0]    FIB_LAST = FW'(FIB_TERMS);

    code_kind_t       code_kind_reg;
    phase_t           phase_reg;
    phase_t           phase_next;
    phase_t           eff_phase;
    logic [LEN_W-1:0] bits_left_reg;
    logic [LEN_W-1:0] bits_left_next;
    logic [AW-1:0]    accum_reg;
    logic [AW-1:0]    accum_next;
    logic [VW-1:0]    group_len_reg;
    logic [VW-1:0]    group_len_next;
    logic             prev_one_reg;
    logic             prev_one_next;
    logic [FW-1:0]    fib_idx_reg;
    logic [FW-1:0]    fib_idx_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic             emit;
    logic [VW-1:0]    emit_val;
    logic             emit_ovf;

    logic             vsh_ovf;
    logic [VW-1:0]    vsh;
    logic [LEN_W-1:0] lsh;
    logic             bl_zero;
    logic             bl_one;
    logic [LEN_W-1:0] bl_dec;
    logic [LEN_W-1:0] bl_inc;
    logic [AW-1:0]    gl_wide;
    logic [LEN_W-1:0] gl_clip;
    logic             len_big;
    logic             fib_lt;
    logic [VW:0]      wsel;
    logic [VW:0]      fib_sum;
    logic [FW-1:0]    fib_idx_inc;

    // Fibonacci weights, clipped just above the value range
    logic [VW:0] weight_tab [FIB_TERMS];

    for (genvar gi = 0; gi < FIB_TERMS; gi++)
    begin : g_weight
        assign weight_tab[gi] = (VW + 1)'(fib_weight_cap(gi, VW));
    end

    // Shift one bit into the value, saturating at the value range
    assign vsh_ovf = accum_reg[VW-1];
    assign vsh     = vsh_ovf ? VMASK : {accum_reg[VW-2:0], bit_val};

    // Shift one bit into a length, saturating at the length cap
    assign lsh = accum_reg[LEN_W-1] ? LEN_CAP : {accum_reg[LEN_W-2:0], bit_val};

    // Counter helpers
    assign bl_zero = (bits_left_reg == '0);
    assign bl_one  = (bits_left_reg == LEN_ONE);
    assign bl_dec  = bits_left_reg - LEN_ONE;
    assign bl_inc  = (bits_left_reg == LEN_CAP) ? LEN_CAP : bits_left_reg + LEN_ONE;
    assign gl_wide = AW'(group_len_reg);
    assign gl_clip = (gl_wide < AW'(LEN_CAP)) ? LEN_W'(gl_wide) : LEN_CAP;
    assign len_big = (lsh > LEN_W'(VALUE_BITS));

    // Fibonacci weight lookup and add
    assign fib_lt      = (fib_idx_reg < FIB_LAST);
    assign wsel        = fib_lt ? weight_tab[fib_idx_reg[IW-1:0]] : '0;
    assign fib_sum     = {1'b0, accum_reg[VW-1:0]} + wsel;
    assign fib_idx_inc = fib_lt ? fib_idx_reg + FW'(1) : fib_idx_reg;

    // Pick the code on the first bit of a codeword
    always_comb
    begin
        if (phase_reg == PH_IDLE)
        begin
            case (code_kind_reg)
                CK_GAMMA: eff_phase = PH_GZERO;
                CK_DELTA: eff_phase = PH_DZERO;
                CK_OMEGA: eff_phase = PH_OMEGA;
                default:  eff_phase = PH_FIB;
            endcase
        end
        else
        begin
            eff_phase = phase_reg;
        end
    end

    // Result of this bit, if it ends a codeword
    always_comb
    begin
        emit     = 1'b0;
        emit_val = VW'(1);
        emit_ovf = ovf_reg;
        case (eff_phase)
            PH_GZERO, PH_DZERO:
            begin
                emit = bit_val && bl_zero;
            end
            PH_GBODY, PH_DBODY:
            begin
                emit     = bl_one;
                emit_val = vsh;
                emit_ovf = ovf_reg || vsh_ovf;
            end
            PH_OMEGA:
            begin
                emit     = bl_zero && !bit_val;
                emit_val = group_len_reg;
            end
            PH_FIB:
            begin
                emit     = bit_val && prev_one_reg;
                emit_val = accum_reg[VW-1:0];
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign result.value    = OUT_W'(emit_ovf ? VMASK : emit_val);
    assign result.overflow = emit_ovf;
    assign stat.emit       = emit;
    assign stat.idle       = (phase_reg == PH_IDLE);

    // Next phase
    always_comb
    begin
        phase_next = eff_phase;
        case (eff_phase)
            PH_GZERO:
            begin
                if (bit_val && !bl_zero)
                    phase_next = PH_GBODY;
            end
            PH_DZERO:
            begin
                if (bit_val && !bl_zero)
                    phase_next = PH_DLEN;
            end
            PH_DLEN:
            begin
                if (bl_one)
                    phase_next = PH_DBODY;
            end
            default:
            begin
                phase_next = eff_phase;
            end
        endcase
        if (emit)
            phase_next = PH_IDLE;
    end

    // Next counters, value and flags
    always_comb
    begin
        bits_left_next = bits_left_reg;
        accum_next     = accum_reg;
        group_len_next = group_len_reg;
        prev_one_next  = prev_one_reg;
        fib_idx_next   = fib_idx_reg;
        ovf_next       = ovf_reg;
        case (eff_phase)
            PH_GZERO, PH_DZERO:
            begin
                if (!bit_val)
                    bits_left_next = bl_inc;
                else if (!bl_zero)
                    accum_next = AW'(1);
            end
            PH_GBODY, PH_DBODY:
            begin
                accum_next     = AW'(vsh);
                ovf_next       = ovf_reg || vsh_ovf;
                bits_left_next = bl_dec;
            end
            PH_DLEN:
            begin
                accum_next     = AW'(lsh);
                bits_left_next = bl_dec;
                if (bl_one)
                begin
                    ovf_next       = ovf_reg || len_big;
                    bits_left_next = lsh - LEN_ONE;
                    accum_next     = AW'(1);
                end
            end
            PH_OMEGA:
            begin
                if (bl_zero)
                begin
                    if (bit_val)
                    begin
                        accum_next     = AW'(1);
                        bits_left_next = gl_clip;
                    end
                end
                else
                begin
                    accum_next     = AW'(vsh);
                    ovf_next       = ovf_reg || vsh_ovf;
                    bits_left_next = bl_dec;
                    if (bl_one)
                        group_len_next = vsh;
                end
            end
            PH_FIB:
            begin
                if (bit_val)
                begin
                    if (!fib_lt)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (fib_sum[VW])
                    begin
                        ovf_next   = 1'b1;
                        accum_next = AW'(VMASK);
                    end
                    else
                    begin
                        accum_next = AW'(fib_sum[VW-1:0]);
                    end
                    prev_one_next = 1'b1;
                end
                else
                begin
                    prev_one_next = 1'b0;
                end
                fib_idx_next = fib_idx_inc;
            end
            default:
            begin
                accum_next = accum_reg;
            end
        endcase
        // Drop all codeword state once a result leaves
        if (emit)
        begin
            bits_left_next = '0;
            accum_next     = '0;
            group_len_next = VW'(1);
            prev_one_next  = 1'b0;
            fib_idx_next   = '0;
            ovf_next       = 1'b0;
        end
    end

    // Advance the codeword state on each taken bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bits_left_reg <= '0;
            accum_reg     <= '0;
            group_len_reg <= VW'(1);
            prev_one_reg  <= 1'b0;
            fib_idx_reg   <= '0;
            ovf_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
            accum_reg     <= accum_next;
            group_len_reg <= group_len_next;
            prev_one_reg  <= prev_one_next;
            fib_idx_reg   <= fib_idx_next;
            ovf_reg       <= ovf_next;
        end
    end

    // Code selection register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_kind_reg <= CK_OMEGA;
        else if (cfg_wr_en)
            code_kind_reg <= code_kind_t'(cfg_wr_data);
    end

endmodule

// ===== src/ucd_output_reg.sv =====
// Output register stage: holds one decoded integer until the downstream side takes it.
module ucd_output_reg
    import ucd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  ucd_result_t res_in,
    input  logic        out_ready,
    output logic        out_valid,
    output ucd_result_t out_res,
    output logic        free
);

    logic        valid_reg;
    logic        valid_next;
    ucd_result_t res_reg;

    // Room for a new result when empty or draining this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the bit-serial universal integer code decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ucd_pkg::*;

    localparam int          LATENCY     = 2;
    localparam int          RANDOM_BITS = 480;
    localparam int          PHASE_BITS  = 120;
    localparam int          FIB_TABLE   = 90;
    localparam logic [63:0] VMASK       = (64'd1 << VALUE_BITS_DEF) - 64'd1;
    localparam logic [63:0] LEN_CAP     = 64'h1_FFFF_FFFF;

    // Decoder state, one copy for checking and one that tracks the generated stream
    typedef struct packed {
        phase_t      phase;
        logic [63:0] bits_left;
        logic [63:0] accum;
        logic [63:0] group_length;
        logic        prev_one;
        logic [6:0]  fib_idx;
        logic        ovf;
        code_kind_t  kind;
    } dec_state_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;   // [0] bit_in, [7:1] zero
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // [31:0] value
    logic                  m_axis_tuser;         // [0] overflow
    logic                  cfg_wr_en     = 1'b0;
    logic [1:0]            cfg_wr_data   = '0;

    dec_state_t  chk_state;
    dec_state_t  gen_state;
    ucd_result_t decoded_q[$];
    logic        stream_bits[$];
    logic        word_bits[$];
    logic [63:0] fib_w[0:FIB_TABLE-1];
    int          bits_pushed    = 0;
    int          bits_presented = 0;
    int          bits_taken     = 0;
    int          errors         = 0;
    int          send_gap       = 0;
    int          stall_left     = 0;
    logic        bit_taken      = 1'b0;
    logic        hold_off       = 1'b0;
    logic        calm           = 1'b0;

    universal_integer_code_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic dec_state_t fresh_word(input code_kind_t k);
        dec_state_t s;
        s.phase        = PH_IDLE;
        s.bits_left    = '0;
        s.accum        = '0;
        s.group_length = 64'd1;
        s.prev_one     = 1'b0;
        s.fib_idx      = '0;
        s.ovf          = 1'b0;
        s.kind         = k;
        return s;
    endfunction

    // Shift one bit into a value, clipping at lim
    function automatic logic [63:0] shift_sat(input logic [63:0] acc, input logic b,
                                              input logic [63:0] lim, inout logic ovf);
        logic [63:0] v;
        v = (acc << 1) | {63'd0, b};
        if (v > lim)
        begin
            ovf = 1'b1;
            v   = lim;
        end
        return v;
    endfunction

    // Advance the decoder by one stream bit; returns 1 when a codeword ends
    function automatic logic decode_step(inout dec_state_t s, input logic b,
                                         output ucd_result_t r);
        logic        done;
        logic [63:0] word;
        logic        spare;
        done  = 1'b0;
        word  = '0;
        spare = 1'b0;
        r     = '0;
        if (s.phase == PH_IDLE)
        begin
            case (s.kind)
                CK_GAMMA: s.phase = PH_GZERO;
                CK_DELTA: s.phase = PH_DZERO;
                CK_OMEGA: s.phase = PH_OMEGA;
                default:  s.phase = PH_FIB;
            endcase
        end
        case (s.phase)
            PH_GZERO, PH_DZERO:
            begin
                if (!b)
                begin
                    if (s.bits_left < LEN_CAP)
                        s.bits_left = s.bits_left + 64'd1;
                end
                else if (s.bits_left == 0)
                begin
                    done = 1'b1;
                    word = 64'd1;
                end
                else
                begin
                    s.accum = 64'd1;
                    s.phase = (s.phase == PH_GZERO) ? PH_GBODY : PH_DLEN;
                end
            end
            PH_GBODY, PH_DBODY:
            begin
                s.accum     = shift_sat(s.accum, b, VMASK, s.ovf);
                s.bits_left = s.bits_left - 64'd1;
                if (s.bits_left == 0)
                begin
                    done = 1'b1;
                    word = s.accum;
                end
            end
            PH_DLEN:
            begin
                s.accum     = shift_sat(s.accum, b, LEN_CAP, spare);
                s.bits_left = s.bits_left - 64'd1;
                if (s.bits_left == 0)
                begin
                    if (s.accum > VALUE_BITS_DEF)
                        s.ovf = 1'b1;
                    s.bits_left = s.accum - 64'd1;
                    s.accum     = 64'd1;
                    s.phase     = PH_DBODY;
                end
            end
            PH_OMEGA:
            begin
                if (s.bits_left == 0)
                begin
                    if (!b)
                    begin
                        done = 1'b1;
                        word = s.group_length;
                    end
                    else
                    begin
                        s.accum     = 64'd1;
                        s.bits_left = (s.group_length < LEN_CAP) ? s.group_length : LEN_CAP;
                    end
                end
                else
                begin
                    s.accum     = shift_sat(s.accum, b, VMASK, s.ovf);
                    s.bits_left = s.bits_left - 64'd1;
                    if (s.bits_left == 0)
                        s.group_length = s.accum;
                end
            end
            default:
            begin
                if (b)
                begin
                    if (s.prev_one)
                    begin
                        done = 1'b1;
                        word = s.accum;
                    end
                    else
                    begin
                        if (s.fib_idx < FIB_TERMS_DEF)
                        begin
                            if (fib_w[s.fib_idx] > VMASK - s.accum)
                            begin
                                s.ovf   = 1'b1;
                                s.accum = VMASK;
                            end
                            else
                                s.accum = s.accum + fib_w[s.fib_idx];
                        end
                        else
                            s.ovf = 1'b1;
                        s.prev_one = 1'b1;
                    end
                end
                else
                    s.prev_one = 1'b0;
                if (!done && s.fib_idx < FIB_TERMS_DEF)
                    s.fib_idx = s.fib_idx + 7'd1;
            end
        endcase
        if (done)
        begin
            r.value    = s.ovf ? VMASK[OUT_W-1:0] : word[OUT_W-1:0];
            r.overflow = s.ovf;
            s          = fresh_word(s.kind);
        end
        return done;
    endfunction

    function automatic int bit_len(input logic [63:0] n);
        int i;
        for (i = 63; i > 0; i--)
            if (n[i])
                return i + 1;
        return 1;
    endfunction

    // Mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 94)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly small values, some wide ones, a few past the output width
    function automatic logic [63:0] rand_value();
        int          r;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 16);
        if (r < 80)
            return $urandom_range(17, 1000);
        if (r < 92)
            return $urandom_range(1001, 1 << 20);
        if (r < 96)
        begin
            v = 64'($urandom());
            return (v == 0) ? 64'd1 : v;
        end
        if (r < 98)
            return VMASK - 64'($urandom_range(0, 3));
        return VMASK + 64'd1 + ((64'($urandom_range(0, 255)) << 32) | 64'($urandom()));
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR %0t: %s", $realtime, msg);
    endtask

    task automatic push_bit(input logic b);
        ucd_result_t scratch;
        stream_bits = {stream_bits, b};
        bits_pushed++;
        void'(decode_step(gen_state, b, scratch));
    endtask

    // Build the codeword of n in the given code, earliest bit first
    task automatic encode_word(input code_kind_t k, input logic [63:0] n);
        int          len;
        int          zeros;
        int          top;
        int          i;
        logic [63:0] m;
        logic [63:0] rem;
        word_bits.delete();
        case (k)
            CK_GAMMA:
            begin
                len = bit_len(n);
                repeat (len - 1) word_bits = {word_bits, 1'b0};
                for (i = len - 1; i >= 0; i--)
                    word_bits = {word_bits, n[i]};
            end
            CK_DELTA:
            begin
                len   = bit_len(n);
                zeros = bit_len(len) - 1;
                repeat (zeros) word_bits = {word_bits, 1'b0};
                for (i = zeros; i >= 0; i--)
                    word_bits = {word_bits, len[i]};
                for (i = len - 2; i >= 0; i--)
                    word_bits = {word_bits, n[i]};
            end
            CK_OMEGA:
            begin
                word_bits = {word_bits, 1'b0};
                m = n;
                while (m > 1)
                begin
                    len = bit_len(m);
                    for (i = 0; i < len; i++)
                        word_bits.push_front(m[i]);
                    m = len - 1;
                end
            end
            default:
            begin
                top = 0;
                for (i = 0; i < FIB_TABLE; i++)
                    if (fib_w[i] <= n)
                        top = i;
                repeat (top + 1) word_bits = {word_bits, 1'b0};
                rem = n;
                for (i = top; i >= 0; i--)
                begin
                    if (fib_w[i] <= rem)
                    begin
                        rem          = rem - fib_w[i];
                        word_bits[i] = 1'b1;
                    end
                end
                word_bits = {word_bits, 1'b1};
            end
        endcase
    endtask

    // Queue a codeword, or only its first cut bits when cut is not negative
    task automatic send_word(input code_kind_t k, input logic [63:0] n, input int cut);
        int i;
        encode_word(k, n);
        for (i = 0; i < word_bits.size() && (cut < 0 || i < cut); i++)
            push_bit(word_bits[i]);
    endtask

    // Complete whatever codeword is open with bits that end it quickly
    task automatic finish_word();
        while (gen_state.phase != PH_IDLE)
        begin
            case (gen_state.phase)
                PH_GZERO, PH_DZERO, PH_FIB: push_bit(1'b1);
                default:                    push_bit(1'b0);
            endcase
        end
    endtask

    task automatic send_directed(input code_kind_t k);
        send_word(k, 64'd1, -1);
        send_word(k, 64'd2, -1);
        send_word(k, 64'd3, -1);
        send_word(k, 64'd5, -1);
        send_word(k, 64'd16, -1);
        send_word(k, VMASK, -1);
        send_word(k, VMASK + 64'd1, -1);
    endtask

    // Wait for every bit and result to pass, then let the pipeline empty
    task automatic settle();
        while (bits_taken != bits_pushed || decoded_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_code_kind(input code_kind_t k);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        chk_state.kind = k;
        gen_state.kind = k;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sample accepted bits and predict the decoded values
    always @(posedge clk or negedge rst_n)
    begin : take_bits
        ucd_result_t res;
        if (!rst_n)
            bit_taken <= 1'b0;
        else
        begin
            bit_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                bits_taken++;
                if (decode_step(chk_state, s_axis_tdata[0], res))
                    decoded_q = {decoded_q, res};
            end
        end
    end

    // Present stream bits, holding each until its transaction completes
    always @(negedge clk)
    begin : drive_bits
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !bit_taken)
            s_axis_tvalid <= 1'b1;
        else if (send_gap > 0)
        begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end
        else if (stream_bits.size() != 0 && !hold_off)
        begin
            s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, stream_bits.pop_front()};
            s_axis_tvalid <= 1'b1;
            bits_presented++;
            send_gap = calm ? 0 : (($urandom_range(0, 3) == 0) ? gap_len() : 0);
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
    begin : pace_results
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                stall_left = gap_len();
        end
    end

    // Compare each result transaction with the oldest predicted value
    always @(posedge clk)
    begin : check_results
        ucd_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (decoded_q.size() == 0)
                report_mismatch($sformatf("unexpected result value=%0h overflow=%0b",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch($sformatf("value got %0h want %0h",
                                              m_axis_tdata, want.value));
                if (m_axis_tuser !== want.overflow)
                    report_mismatch($sformatf("overflow got %0b want %0b for value %0h",
                                              m_axis_tuser, want.overflow, want.value));
            end
        end
    end

    initial
    begin : stimulus
        int         i;
        int         phase_idx;
        int         rand_start;
        int         phase_start;
        int         r;
        logic       paused;
        code_kind_t kind;

        fib_w[0] = 64'd1;
        fib_w[1] = 64'd2;
        for (i = 2; i < FIB_TABLE; i++)
            fib_w[i] = fib_w[i-1] + fib_w[i-2];
        chk_state = fresh_word(CK_OMEGA);
        gen_state = fresh_word(CK_OMEGA);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Omega straight out of reset, then gamma
        send_directed(CK_OMEGA);
        settle();
        write_code_kind(CK_GAMMA);
        send_directed(CK_GAMMA);

        // Change the code halfway through a gamma codeword of 5
        send_word(CK_GAMMA, 64'd5, 2);
        settle();
        write_code_kind(CK_DELTA);
        push_bit(1'b1);
        push_bit(1'b0);
        push_bit(1'b1);
        send_directed(CK_DELTA);
        settle();
        write_code_kind(CK_FIB);
        send_directed(CK_FIB);
        // Fibonacci weight just past the end of the table
        send_word(CK_FIB, fib_w[FIB_TERMS_DEF], -1);

        // Random phases, each under one code setting
        phase_idx  = 0;
        rand_start = bits_pushed;
        while (bits_pushed - rand_start < RANDOM_BITS)
        begin
            settle();
            kind = (phase_idx < 4) ? code_kind_t'(phase_idx) : code_kind_t'($urandom_range(0, 3));
            write_code_kind(kind);
            calm = ($urandom_range(0, 3) == 0);
            finish_word();
            phase_start = bits_pushed;
            paused      = 1'b0;
            while (bits_pushed - phase_start < PHASE_BITS)
            begin
                // Hold the sender mid-stream until the decoder has caught up
                if (phase_idx % 3 == 1 && !paused && bits_pushed - phase_start >= PHASE_BITS / 2)
                begin
                    while (stream_bits.size() > 8)
                        @(negedge clk);
                    hold_off = 1'b1;
                    @(negedge clk);
                    while (bits_taken != bits_presented || decoded_q.size() != 0)
                        @(negedge clk);
                    hold_off = 1'b0;
                    paused   = 1'b1;
                end
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    repeat ($urandom_range(1, 8)) push_bit(1'($urandom_range(0, 1)));
                    finish_word();
                end
                else if (r == 1)
                begin
                    send_word(kind, rand_value(), $urandom_range(1, 6));
                    finish_word();
                end
                else
                    send_word(kind, rand_value(), -1);
            end
            // Leave a codeword open across the next setting now and then
            if ($urandom_range(0, 1) == 1)
                send_word(kind, rand_value(), $urandom_range(1, 4));
            phase_idx++;
        end

        settle();
        if (errors == 0)
            $display("universal_integer_code_decoder: match");
        else
            $display("universal_integer_code_decoder: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("universal_integer_code_decoder: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ucd_pkg.sv
src/ucd_input_reg.sv
src/ucd_decode_core.sv
src/ucd_output_reg.sv
src/universal_integer_code_decoder.sv
tb/sv/tb_top.sv
